>>> sv/linear_longest_prefix_route_table_assert.svh
// assertion macros for the route table rtl
// no dependencies; included by modules that assert
`ifndef LINEAR_LONGEST_PREFIX_ROUTE_TABLE_ASSERT_SVH
`define LINEAR_LONGEST_PREFIX_ROUTE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define LLPRT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LLPRT_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LLPRT_ASSERT(label, clk, rst, prop, msg)
`define LLPRT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> sv/llprt_pkg.sv
// shared types and constants for the route table
// no dependencies
package llprt_pkg;
  localparam int TableEntriesDefault = 64;
  localparam int PortCountDefault    = 16;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EXISTS    = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NO_ROUTE  = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] prefix_mask;
    logic [31:0] gateway;
    logic [3:0]  out_port;
    logic        may_overwrite;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  port_out;
    logic [31:0] next_hop;
    logic [5:0]  entry_index;
    logic        cache_hit;
    logic [31:0] old_gateway;
    logic [3:0]  old_port;
  } rsp_t;
endpackage

>>> sv/llprt_if.sv
// valid/ready channel carrying one payload
// uses no package; payload type is a parameter
interface llprt_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/llprt_ram.sv
// generic single-port ram with registered read
// no dependencies
module llprt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> sv/linear_longest_prefix_route_table.sv
// ipv4 longest-prefix route table, full linear scan per transaction unless
// a lookup hits the cache. every other lookup, add or remove sweeps all
// TABLE_ENTRIES slots one per cycle through a single-port entry ram whose
// words carry the valid bit. a transaction is accepted in the idle state,
// then scans the slots through the read pipeline and its drain, then
// finishes in the write step, which loads the result register. a lookup
// served from the one-entry last-address cache reads its cached slot in a
// fetch step instead of the scan, then goes to the write step.
// an add or remove that changes a slot writes it in the write cycle. after
// reset a clearing pass zeroes every slot, with the input not ready
// meanwhile. the result sits in an output register until taken, so the
// next transaction can be accepted while it waits; the write cycle stalls
// only while an earlier result is still untaken.
// depends on llprt_pkg, llprt_if, llprt_ram and the assertion header.
`include "linear_longest_prefix_route_table_assert.svh"
module linear_longest_prefix_route_table #(
  parameter int TABLE_ENTRIES = llprt_pkg::TableEntriesDefault,
  parameter int PORT_COUNT    = llprt_pkg::PortCountDefault
) (
  input logic clk,
  input logic rst,
  llprt_if.sink   req,
  llprt_if.source rsp
);
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int PW = 4;
  localparam int EW = 1 + 32 + 32 + 32 + PW;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FETCH = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t state, state_next;
  llprt_pkg::req_t cur;
  llprt_pkg::rsp_t res, res_next;
  logic          out_valid;
  logic [IW:0]   rd_cnt;       // address issued
  logic          rd_live;      // ram data belongs to rd_slot, or cache_slot in fetch
  logic [IW-1:0] rd_slot;
  logic          found;
  logic [IW-1:0] found_slot;
  logic [31:0]   found_mask;
  logic [31:0]   found_gw;
  logic [PW-1:0] found_port;
  logic          free_seen;
  logic [IW-1:0] free_slot;
  logic          done;
  logic          cache_valid;
  logic [31:0]   cache_address;
  logic [IW-1:0] cache_slot;
  logic          from_cache;

  // ram port
  logic          ram_we;
  logic [IW-1:0] ram_addr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic          e_vld;
  logic [31:0]   e_prefix, e_mask, e_gw;
  logic [PW-1:0] e_port;
  logic [PW-1:0] new_port;
  logic [PW-1:0] port_wrap [16];

  assign {e_vld, e_prefix, e_mask, e_gw, e_port} = ram_rdata;

  // port modulo count, as a constant table over the 4-bit port
  for (genvar p = 0; p < 16; p++) begin : g_port_wrap
    assign port_wrap[p] = PW'(p % PORT_COUNT);
  end
  assign new_port = port_wrap[cur.out_port];

  llprt_ram #(.Width(EW), .Depth(TABLE_ENTRIES)) u_ram (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic e_valid, e_equal, e_cover;
  assign e_valid = rd_live && e_vld;
  assign e_equal = e_valid && e_prefix == cur.address && e_mask == cur.prefix_mask;
  assign e_cover = e_valid && ((cur.address ^ e_prefix) & e_mask) == 32'd0;

  // write step completes once the output register is free or being emptied
  logic wr_go;
  assign wr_go = state == S_WRITE && (!out_valid || rsp.ready);

  // add or remove transaction taken this cycle
  logic upd_taken;
  assign upd_taken = req.valid && req.ready && (req.data.kind == llprt_pkg::KIND_ADD
                                                || req.data.kind == llprt_pkg::KIND_REMOVE);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = rd_cnt[IW-1:0];
    ram_wdata = {1'b1, cur.address, cur.prefix_mask, cur.gateway, new_port};
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else if (state == S_FETCH) begin
      ram_addr = cache_slot;
    end else if (wr_go) begin
      ram_addr = found ? found_slot : free_slot;
      if (cur.kind == llprt_pkg::KIND_ADD) begin
        // equal route only rewritten when overwrite is allowed, nothing when full
        ram_we = found ? cur.may_overwrite : free_seen;
      end else if (cur.kind == llprt_pkg::KIND_REMOVE) begin
        ram_we    = found;
        ram_wdata = '0;
      end
    end
  end

  assign req.ready = state == S_IDLE;
  assign rsp.valid = out_valid;
  assign rsp.data  = res;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (rd_cnt == (IW+1)'(TABLE_ENTRIES - 1)) state_next = S_IDLE;
      S_IDLE:  if (req.valid && req.data.kind != llprt_pkg::KIND_UNUSED) begin
        if (req.data.kind == llprt_pkg::KIND_LOOKUP && req.data.address != 32'd0
            && cache_valid && req.data.address == cache_address) begin
          state_next = S_FETCH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN:  if (!rd_live && rd_cnt == (IW+1)'(TABLE_ENTRIES)) state_next = S_WRITE;
      S_FETCH: if (rd_live) state_next = S_WRITE;
      S_WRITE: if (!out_valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // result of the finished transaction
  always_comb begin
    res_next = '0;
    unique case (cur.kind)
      llprt_pkg::KIND_LOOKUP: begin
        if (!found) begin
          res_next.status = llprt_pkg::ST_NO_ROUTE;
        end else begin
          res_next.status      = llprt_pkg::ST_OK;
          res_next.port_out    = found_port;
          res_next.next_hop    = found_gw != 32'd0 ? found_gw : cur.address;
          res_next.entry_index = 6'(found_slot);
          res_next.cache_hit   = from_cache;
        end
      end
      llprt_pkg::KIND_ADD: begin
        if (found) begin
          res_next.status      = cur.may_overwrite ? llprt_pkg::ST_OK
                                                   : llprt_pkg::ST_EXISTS;
          res_next.entry_index = 6'(found_slot);
          res_next.old_gateway = found_gw;
          res_next.old_port    = found_port;
        end else if (!free_seen) begin
          res_next.status = llprt_pkg::ST_FULL;
        end else begin
          res_next.entry_index = 6'(free_slot);
        end
      end
      default: begin
        if (found) begin
          res_next.entry_index = 6'(found_slot);
          res_next.old_gateway = found_gw;
          res_next.old_port    = found_port;
        end else begin
          res_next.status = llprt_pkg::ST_NOT_FOUND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      rd_cnt      <= '0;
      out_valid   <= 1'b0;
      cache_valid <= 1'b0;
      cache_address <= '0;
      cache_slot  <= '0;
      rd_live     <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          rd_cnt <= rd_cnt + (IW+1)'(1);
        end
        S_IDLE: begin
          cur        <= req.data;
          rd_cnt     <= '0;
          rd_live    <= 1'b0;
          found      <= 1'b0;
          free_seen  <= 1'b0;
          done       <= 1'b0;
          from_cache <= 1'b0;
          if (upd_taken) begin
            cache_valid <= 1'b0;
          end
        end
        S_SCAN: begin
          // one ram read per cycle, compared in the cycle after
          rd_live <= rd_cnt != (IW+1)'(TABLE_ENTRIES);
          rd_slot <= rd_cnt[IW-1:0];
          if (rd_cnt != (IW+1)'(TABLE_ENTRIES)) rd_cnt <= rd_cnt + (IW+1)'(1);
          if (rd_live) begin
            if (cur.kind == llprt_pkg::KIND_LOOKUP) begin
              if (e_cover && (!found || (e_mask & found_mask) == found_mask)) begin
                found <= 1'b1; found_slot <= rd_slot; found_mask <= e_mask;
                found_gw <= e_gw; found_port <= e_port;
              end
            end else if (!done) begin
              if (!e_vld && cur.kind == llprt_pkg::KIND_ADD) begin
                if (!free_seen) begin
                  free_seen <= 1'b1; free_slot <= rd_slot;
                end
              end else if (e_equal) begin
                found <= 1'b1; done <= 1'b1; found_slot <= rd_slot;
                found_gw <= e_gw; found_port <= e_port;
              end
            end
          end
        end
        S_FETCH: begin
          rd_live <= 1'b1;
          if (rd_live) begin
            found <= 1'b1; from_cache <= 1'b1; found_slot <= cache_slot;
            found_gw <= e_gw; found_port <= e_port;
          end
        end
        S_WRITE: begin
          if (wr_go) begin
            res <= res_next;
            // remember the last nonzero address that found a route
            if (cur.kind == llprt_pkg::KIND_LOOKUP && found && !from_cache
                && cur.address != 32'd0) begin
              cache_valid <= 1'b1; cache_address <= cur.address;
              cache_slot <= found_slot;
            end
          end
        end
        default: ;
      endcase
    end
  end

  logic rsp_stall;
  assign rsp_stall = rsp.valid && !rsp.ready;

  `LLPRT_ASSERT(a_rsp_hold, clk, rst, rsp_stall |=> rsp.valid && $stable(rsp.data), "result dropped")
  `LLPRT_ASSERT(a_out_src, clk, rst, rsp.valid && !$past(rsp.valid) |-> $past(wr_go), "no write")
  `LLPRT_ASSERT(a_cache_clear, clk, rst, $past(upd_taken) |-> !cache_valid, "cache survived update")
endmodule
